>>> hdl/ssps_pkg.sv
package ssps_pkg;

  // Segment capacity and derived index width
  localparam int SEG_SIZE = 4096;
  localparam int SEG_AW   = $clog2(SEG_SIZE);

  // Field widths
  localparam int VAL_W  = 32;
  localparam int ROOT_W = VAL_W / 2;
  localparam int SUM_W  = 44;
  localparam int DIV_CW = $clog2(VAL_W);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

>>> hdl/ssps_ram.sv
module ssps_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/segmented_sieve_prime_sum_top.sv
// Segmented sieve: sum of the primes in [segment_begin, segment_end].
//
// Request channel: drive segment_begin/segment_end and raise start; the beat
// is taken at a rising edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle with prime_sum and
// range_error valid. The receiver cannot stall; it must take the beat then.
// A reversed segment, or one longer than SEG_SIZE numbers, answers in the
// cycle after its beat is taken with range_error set and a zero sum, and busy never rises.
// A valid request refills the bitmap, finds root = isqrt(end), then for
// each odd d in 3..root takes the remainder of begin by d when begin > d*d
// (one quotient bit per cycle) and strikes the odd multiples of d, and
// ends with a summing pass over the n = end - begin + 1 numbers.
// The per-divisor remainder unit and the single write port of the bitmap
// set how long a request takes.
// The bitmap is refilled with ones before each request is sieved, so reset
// clears only the control state and takes no clearing pass.
module segmented_sieve_prime_sum_top
  import ssps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [VAL_W-1:0]     segment_begin,
  input  logic [VAL_W-1:0]     segment_end,
  output logic                 done,
  output logic [SUM_W-1:0]     prime_sum,
  output logic                 range_error
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_ROOT, S_DCHK, S_DSTART, S_DIV, S_ALIGN, S_STRIKE, S_SUM, S_TAIL
  } state_t;

  state_t state;

  // Request registers
  logic [VAL_W-1:0]  lo;
  logic [VAL_W-1:0]  hi;
  logic [SEG_AW-1:0] last;
  logic [SEG_AW-1:0] idx;

  // Square root search
  logic [ROOT_W-1:0]         root;
  logic [$clog2(ROOT_W)-1:0] sq_bit;
  logic [ROOT_W-1:0]         sq_try;
  logic [VAL_W-1:0]          sq_prod;

  // Divisor loop
  logic [ROOT_W:0]   d;
  logic [VAL_W-1:0]  dsq;
  logic [ROOT_W:0]   rem;
  logic [ROOT_W:0]   rem_sh;
  logic [VAL_W-1:0]  div_q;
  logic [DIV_CW-1:0] div_cnt;
  logic [ROOT_W:0]   off_base;
  logic [ROOT_W+1:0] off;
  logic [VAL_W+1:0]  m;
  logic              strike_hit;
  logic [VAL_W+1:0]  m_rel;

  // Summing pipeline
  logic              p_valid;
  logic [VAL_W-1:0]  p_v;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [SUM_W:0]    sum_add;

  // Request check
  logic [VAL_W:0]    diff;
  logic              req_err;

  // Bitmap port
  logic              mem_we;
  logic [SEG_AW-1:0] mem_waddr;
  logic              mem_wdata;
  logic              mem_rdata;

  assign busy = (state != S_IDLE);

  assign diff    = {1'b0, segment_end} - {1'b0, segment_begin};
  assign req_err = diff[VAL_W] || (diff[VAL_W-1:0] >= VAL_W'(SEG_SIZE));

  assign sq_try  = root | (ROOT_W'(1) << sq_bit);
  assign sq_prod = VAL_W'(sq_try) * VAL_W'(sq_try);

  // One restoring step of begin mod d
  always_comb begin
    rem_sh = {rem[ROOT_W-1:0], div_q[VAL_W-1]};
    if (rem_sh >= d) begin
      rem_sh = rem_sh - d;
    end
  end

  // Offset from begin to the first odd multiple of d at or above it
  always_comb begin
    off_base = (rem == '0) ? '0 : (d - rem);
    off      = {1'b0, off_base};
    if (lo[0] == off_base[0]) begin
      off = off + {1'b0, d};
    end
  end

  assign strike_hit = (m <= {2'b00, hi});
  assign m_rel      = m - {2'b00, lo};

  // Odd survivors of at least 3 enter the sum; saturate at the field limit
  assign sum_add = {1'b0, sum} + (SUM_W+1)'(p_v);
  always_comb begin
    sum_next = sum;
    if (p_valid && p_v[0] && (p_v >= VAL_W'(3)) && mem_rdata) begin
      sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    end
  end

  // Refill writes ones, striking writes zeros
  assign mem_we    = (state == S_CLEAR) || ((state == S_STRIKE) && strike_hit);
  assign mem_waddr = (state == S_CLEAR) ? idx : m_rel[SEG_AW-1:0];
  assign mem_wdata = (state == S_CLEAR);

  ssps_ram #(
    .WIDTH (1),
    .DEPTH (SEG_SIZE)
  ) u_bits (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      p_valid     <= 1'b0;
      range_error <= 1'b0;
      prime_sum   <= '0;
    end else begin
      done    <= 1'b0;
      p_valid <= 1'b0;
      sum     <= sum_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            lo   <= segment_begin;
            hi   <= segment_end;
            last <= diff[SEG_AW-1:0];
            idx  <= '0;
            if (req_err) begin
              // Answer at once, leave the bitmap alone
              done        <= 1'b1;
              range_error <= 1'b1;
              prime_sum   <= '0;
            end else begin
              sum   <= ((segment_begin <= VAL_W'(2)) && (segment_end >= VAL_W'(2)))
                       ? SUM_W'(2) : '0;
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (idx == last) begin
            root   <= '0;
            sq_bit <= '1;
            state  <= S_ROOT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_ROOT: begin
          if (sq_prod <= hi) begin
            root <= sq_try;
          end
          if (sq_bit == '0) begin
            d     <= (ROOT_W+1)'(3);
            state <= S_DCHK;
          end else begin
            sq_bit <= sq_bit - 1'b1;
          end
        end
        S_DCHK: begin
          if (d > {1'b0, root}) begin
            idx   <= '0;
            state <= S_SUM;
          end else begin
            dsq   <= VAL_W'(d[ROOT_W-1:0]) * VAL_W'(d[ROOT_W-1:0]);
            state <= S_DSTART;
          end
        end
        S_DSTART: begin
          if (lo > dsq) begin
            rem     <= '0;
            div_q   <= lo;
            div_cnt <= '1;
            state   <= S_DIV;
          end else begin
            // d*d is odd and already a multiple of d
            m     <= {2'b00, dsq};
            state <= S_STRIKE;
          end
        end
        S_DIV: begin
          rem   <= rem_sh;
          div_q <= div_q << 1;
          if (div_cnt == '0) begin
            state <= S_ALIGN;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_ALIGN: begin
          m     <= {2'b00, lo} + (VAL_W+2)'(off);
          state <= S_STRIKE;
        end
        S_STRIKE: begin
          if (strike_hit) begin
            m <= m + (VAL_W+2)'({d, 1'b0});
          end else begin
            d     <= d + (ROOT_W+1)'(2);
            state <= S_DCHK;
          end
        end
        S_SUM: begin
          // Issue one read a beat; data lands next cycle with its value
          p_valid <= 1'b1;
          p_v     <= lo + VAL_W'(idx);
          if (idx == last) begin
            state <= S_TAIL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_TAIL: begin
          done        <= 1'b1;
          range_error <= 1'b0;
          prime_sum   <= sum_next;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a request is in progress");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
      (done && range_error) |-> (prime_sum == '0))
    else $error("range error reported with a nonzero sum");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
      $rose(busy) |-> $past(start))
    else $error("busy rose without a start beat");

  a_strike_in_seg: assert property (@(posedge clk) disable iff (rst)
      ((state == S_STRIKE) && strike_hit) |-> (m_rel <= (VAL_W+2)'(last)))
    else $error("strike outside the segment");
`endif

endmodule

>>> sim/prime_sum_checker.sv
module prime_sum_checker
  import ssps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [VAL_W-1:0] segment_begin,
  input  logic [VAL_W-1:0] segment_end,
  input  logic             done,
  input  logic [SUM_W-1:0] prime_sum,
  input  logic             range_error,
  output int               mismatch_count,
  output int               outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             err;
  } prime_answer_t;

  prime_answer_t pending_sums[$];
  bit            cand_map[SEG_SIZE];
  int            fail_tally;

  assign mismatch_count = fail_tally;

  // Sieve the segment the same way the block does and sum the odd survivors, plus 2 when the segment holds it.
  function automatic prime_answer_t sieve_segment_sum(input logic [VAL_W-1:0] lo,
                                                      input logic [VAL_W-1:0] hi);
    prime_answer_t   ans;
    longint unsigned lo_v, hi_v, root, trial, d, m, first, acc, v;
    int              span, b, idx;
    ans.sum = '0;
    ans.err = 1'b0;
    lo_v = lo;
    hi_v = hi;
    if (hi_v < lo_v || hi_v - lo_v + 1 > SEG_SIZE) begin
      ans.err = 1'b1;
      return ans;
    end
    span = int'(hi_v - lo_v + 1);
    foreach (cand_map[i]) cand_map[i] = 1'b1;

    // floor(sqrt(hi)), one root bit per step
    root = 0;
    for (b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= hi_v) root = trial;
    end

    // strike odd multiples from max(d*d, begin) upward
    for (d = 3; d <= root; d += 2) begin
      first = d * d;
      if (lo_v > first) first = lo_v;
      m = ((first + d - 1) / d) * d;
      if (m[0] == 1'b0) m += d;
      while (m <= hi_v) begin
        cand_map[int'(m - lo_v)] = 1'b0;
        m += 2 * d;
      end
    end

    acc = (lo_v <= 2 && hi_v >= 2) ? 64'd2 : 64'd0;
    for (idx = 0; idx < span; idx++) begin
      v = lo_v + idx;
      if (v[0] && v >= 3 && cand_map[idx]) begin
        acc += v;
        if (acc > SUM_MAX) acc = SUM_MAX;
      end
    end
    ans.sum = acc[SUM_W-1:0];
    return ans;
  endfunction

  // Push first, then retire: a result may leave on the edge a new beat comes in.
  always @(posedge clk) begin
    prime_answer_t want;
    if (rst) begin
      pending_sums.delete();
      fail_tally  = 0;
      outstanding <= 0;
    end else begin
      if (start && !busy)
        pending_sums.insert(pending_sums.size(),
                            sieve_segment_sum(segment_begin, segment_end));
      if (done) begin
        if (pending_sums.size() == 0) begin
          $error("result beat with no request waiting: prime_sum=%0d range_error=%0b",
                 prime_sum, range_error);
          fail_tally++;
        end else begin
          want = pending_sums.pop_front();
          if (prime_sum !== want.sum) begin
            $error("prime_sum: expected %0d, got %0d", want.sum, prime_sum);
            fail_tally++;
          end
          if (range_error !== want.err) begin
            $error("range_error: expected %0b, got %0b", want.err, range_error);
            fail_tally++;
          end
        end
      end
      outstanding <= pending_sums.size();
    end
  end

endmodule

>>> sim/tb_top.sv
module tb_top;

  import ssps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Idle cycles allowed with neither a request nor a result beat. A request
  // near the top of the 32-bit range runs the longest divisor loop.
  localparam int IDLE_LIMIT  = 4_000_000;
  localparam int RAND_ITEMS  = 100;
  localparam int TAIL_CYCLES = 100;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  logic [VAL_W-1:0] segment_begin;
  logic [VAL_W-1:0] segment_end;
  logic             done;
  logic [SUM_W-1:0] prime_sum;
  logic             range_error;

  int mismatch_count;
  int outstanding;
  int idle_cycles;
  bit no_gaps;

  always #5 clk = ~clk;

  segmented_sieve_prime_sum_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .segment_begin (segment_begin),
    .segment_end   (segment_end),
    .done          (done),
    .prime_sum     (prime_sum),
    .range_error   (range_error)
  );

  prime_sum_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .segment_begin  (segment_begin),
    .segment_end    (segment_end),
    .done           (done),
    .prime_sum      (prime_sum),
    .range_error    (range_error),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Often back-to-back, some short gaps, a few long ones that run past the
  // end of a busy period so the next beat lands at varied points.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 30);
    return $urandom_range(100, 2000);
  endfunction

  // Present one request beat and hold it until the block takes it.
  // Returns on the edge of acceptance; start stays high so the next beat
  // can follow without a low cycle in between.
  task automatic send_segment(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    segment_begin <= lo;
    segment_end   <= hi;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and hold off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // One random request: mostly valid segments with small ends to keep the
  // divisor loop short, some mid-range ends, and a share of bad segments
  // drawn from the full 32-bit range (these answer at once and cover the
  // upper bits of both fields).
  task automatic send_random_segment();
    logic [VAL_W-1:0] lo, hi;
    longint unsigned  room;
    int               r, len_kind, len;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // reversed segment
      lo = $urandom;
      if (lo == 0) lo = 1;
      hi = ($urandom_range(0, 3) == 0) ? lo - 1 : $urandom_range(0, lo - 1);
    end else if (r < 16) begin
      // longer than capacity, sometimes by exactly one number
      lo   = $urandom_range(0, 32'hFFFF_EFFF);
      room = 64'hFFFF_FFFF - lo - SEG_SIZE;
      hi   = lo + SEG_SIZE;
      if ($urandom_range(0, 3) != 0) hi = hi + $urandom_range(0, 32'(room));
    end else begin
      hi = (r < 88) ? $urandom_range(0, 20000) : $urandom_range(0, 1 << 20);
      len_kind = $urandom_range(0, 9);
      if (len_kind < 2)       len = $urandom_range(1, 8);
      else if (len_kind < 8)  len = $urandom_range(1, 300);
      else if (len_kind == 8) len = $urandom_range(1, SEG_SIZE);
      else                    len = SEG_SIZE;
      lo = (hi + 1 > len) ? hi + 1 - len : '0;
    end
    send_segment(lo, hi);
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    segment_begin = '0;
    segment_end   = '0;
    no_gaps       = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: tiny segments around 0, 1 and 2
    send_segment(0, 0);
    send_segment(1, 1);
    send_segment(0, 1);
    send_segment(2, 2);
    send_segment(1, 2);
    send_segment(3, 3);
    // squares of primes, a single prime near 2^16, a span starting on a prime
    send_segment(9, 9);
    send_segment(49, 49);
    send_segment(65521, 65521);
    send_segment(3, 100);
    // full capacity, from zero and from above the small squares
    send_segment(0, SEG_SIZE - 1);
    send_segment(1000, 1000 + SEG_SIZE - 1);
    send_segment(1 << 20, (1 << 20) + SEG_SIZE - 1);
    // one past capacity, reversed by one, reversed and too long across the whole range
    send_segment(0, SEG_SIZE);
    send_segment(4000, 4000 + SEG_SIZE);
    send_segment(5, 4);
    send_segment(32'hFFFF_FFFF, 0);
    send_segment(0, 32'hFFFF_FFFF);
    // top of the range: the largest 32-bit prime sits in here
    send_segment(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_segment(32'hFFFF_FFFF, 32'hFFFF_FFFE);

    // Let the pipe empty once before the random beats
    drain_results();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      // every 20 beats, maybe switch to a burst with no idle gaps
      if (i % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_random_segment();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
